/* design/deadline_timer_table_top_macros.svh */
// ----------------------------------------------------------------------------
// Deadline timer table assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_TABLE_TOP_MACROS_SVH
`define DEADLINE_TIMER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DTT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("deadline timer table check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define DTT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("deadline timer table check failed");

`endif

/* design/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// Deadline timer table package
// Sizes, operation and outcome codes, and the command passed front to back.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int NUM_TIMERS   = 32;
  localparam int SLOT_W       = $clog2(NUM_TIMERS);
  localparam int RESULT_LIMIT = 32;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  localparam int ID_W    = 5;
  localparam int DELAY_W = 16;
  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int DL_W    = SEC_W + USEC_W;

  localparam int S_FIELDS_W = ID_W + DELAY_W + SEC_W + USEC_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((ID_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_TICK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    OUT_DONE        = 2'd0,
    OUT_NOT_PENDING = 2'd1,
    OUT_FIRED       = 2'd2,
    OUT_NONE_DUE    = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    CMD_ARM,
    CMD_CANCEL,
    CMD_EXPIRE,
    CMD_TICK,
    CMD_BAD_SLOT
  } cmd_kind_t;

  // For arm and expire, sec/usec is the new deadline; for tick it is now.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [ID_W-1:0]   slot;
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
  } cmd_t;

endpackage

/* design/dtt_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/dtt_front.sv */
// ----------------------------------------------------------------------------
// Deadline timer table front end
// Accepts input transfers, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module dtt_front import dtt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 q_valid,
  input  logic                 q_ready,
  output cmd_t                 q_cmd
);

  logic [ID_W-1:0]    timer_id;
  logic [DELAY_W-1:0] delay_seconds;
  logic [SEC_W-1:0]   now_sec;
  logic [USEC_W-1:0]  now_usec;
  logic [SEC_W:0]     arm_sum;
  logic [SEC_W-1:0]   arm_sec;
  logic               bad_slot;
  cmd_t               cmd_in;

  cmd_t        entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign timer_id      = s_tdata[ID_W-1:0];
  assign delay_seconds = s_tdata[ID_W+DELAY_W-1:ID_W];
  assign now_sec       = s_tdata[ID_W+DELAY_W+SEC_W-1:ID_W+DELAY_W];
  assign now_usec      = s_tdata[S_FIELDS_W-1:ID_W+DELAY_W+SEC_W];

  // Arm deadline saturates at the largest seconds value.
  assign arm_sum  = {1'b0, now_sec} + {{(SEC_W + 1 - DELAY_W){1'b0}}, delay_seconds};
  assign arm_sec  = arm_sum[SEC_W] ? {SEC_W{1'b1}} : arm_sum[SEC_W-1:0];
  assign bad_slot = (int'(timer_id) >= NUM_TIMERS);

  always_comb begin
    cmd_in.slot = timer_id;
    cmd_in.sec  = now_sec;
    cmd_in.usec = now_usec;
    unique case (opcode_t'(s_tuser))
      OP_ARM: begin
        cmd_in.kind = bad_slot ? CMD_BAD_SLOT : CMD_ARM;
        cmd_in.sec  = arm_sec;
      end
      OP_CANCEL: cmd_in.kind = bad_slot ? CMD_BAD_SLOT : CMD_CANCEL;
      OP_EXPIRE: cmd_in.kind = bad_slot ? CMD_BAD_SLOT : CMD_EXPIRE;
      default:   cmd_in.kind = CMD_TICK;
    endcase
  end

  // Two-entry command queue.
  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = entry[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= cmd_in;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* design/dtt_back.sv */
// ----------------------------------------------------------------------------
// Deadline timer table back end
// Executes queued commands against the timer table and drives results.
// ----------------------------------------------------------------------------
module dtt_back import dtt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  cmd_t                 q_cmd,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FLUSH
  } state_t;

  state_t              state;
  cmd_t                cmd;
  logic [NUM_TIMERS-1:0] pending;
  logic [SLOT_W-1:0]   scan_addr;
  logic                rd_valid;
  logic [SLOT_W-1:0]   rd_idx;
  logic                found;
  logic [SLOT_W-1:0]   best_idx;
  logic [SEC_W-1:0]    best_sec;
  logic [USEC_W-1:0]   best_usec;
  logic                held_valid;
  logic [SLOT_W-1:0]   held_idx;
  logic [CNT_W-1:0]    fire_cnt;
  logic                out_valid;
  logic [ID_W-1:0]     out_slot;
  outcome_t            out_outcome;
  logic                out_last;

  logic                out_ready;
  logic [SLOT_W-1:0]   cmd_slot;
  logic                wr_en;
  logic [DL_W-1:0]     rd_data;
  logic [SEC_W-1:0]    rd_sec;
  logic [USEC_W-1:0]   rd_usec;
  logic                due;
  logic                earlier;
  logic                take;

  assign out_ready = !out_valid || m_tready;
  assign cmd_slot  = SLOT_W'(cmd.slot);
  assign q_ready   = (state == ST_IDLE);
  assign wr_en     = (state == ST_EXEC) && out_ready &&
                     ((cmd.kind == CMD_ARM) || (cmd.kind == CMD_EXPIRE));

  dtt_ram #(
    .WIDTH (DL_W),
    .DEPTH (NUM_TIMERS)
  ) u_deadline_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmd_slot),
    .wr_data ({cmd.sec, cmd.usec}),
    .rd_en   (state == ST_SCAN),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  assign rd_sec  = rd_data[DL_W-1:USEC_W];
  assign rd_usec = rd_data[USEC_W-1:0];

  // A slot is due at or before now; strictly earlier keeps the lowest index on ties.
  assign due     = (rd_sec < cmd.sec) || ((rd_sec == cmd.sec) && (rd_usec <= cmd.usec));
  assign earlier = (rd_sec < best_sec) || ((rd_sec == best_sec) && (rd_usec < best_usec));
  assign take    = rd_valid && pending[rd_idx] && due && (!found || earlier);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pending    <= '0;
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      held_valid <= 1'b0;
      fire_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      rd_valid <= (state == ST_SCAN);
      rd_idx   <= scan_addr;
      if (take) begin
        found     <= 1'b1;
        best_idx  <= rd_idx;
        best_sec  <= rd_sec;
        best_usec <= rd_usec;
      end

      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            if (q_cmd.kind == CMD_TICK) begin
              state      <= ST_SCAN;
              scan_addr  <= '0;
              found      <= 1'b0;
              held_valid <= 1'b0;
              fire_cnt   <= '0;
            end else begin
              state <= ST_EXEC;
            end
          end
        end

        ST_EXEC: begin
          if (out_ready) begin
            out_valid <= 1'b1;
            out_slot  <= cmd.slot;
            out_last  <= 1'b1;
            case (cmd.kind)
              CMD_ARM, CMD_EXPIRE: begin
                pending[cmd_slot] <= 1'b1;
                out_outcome       <= OUT_DONE;
              end
              CMD_CANCEL: begin
                pending[cmd_slot] <= 1'b0;
                out_outcome       <= pending[cmd_slot] ? OUT_DONE : OUT_NOT_PENDING;
              end
              default: out_outcome <= OUT_NOT_PENDING;
            endcase
            state <= ST_IDLE;
          end
        end

        ST_SCAN: begin
          scan_addr <= scan_addr + SLOT_W'(1);
          if (scan_addr == SLOT_W'(NUM_TIMERS - 1)) begin
            state <= ST_DRAIN;
          end
        end

        ST_DRAIN: state <= ST_DECIDE;

        ST_DECIDE: begin
          if (found) begin
            if (!held_valid || out_ready) begin
              if (held_valid) begin
                out_valid   <= 1'b1;
                out_slot    <= ID_W'(held_idx);
                out_outcome <= OUT_FIRED;
                out_last    <= 1'b0;
              end
              held_valid        <= 1'b1;
              held_idx          <= best_idx;
              pending[best_idx] <= 1'b0;
              fire_cnt          <= fire_cnt + CNT_W'(1);
              if (fire_cnt == CNT_W'(RESULT_LIMIT - 1)) begin
                state <= ST_FLUSH;
              end else begin
                state     <= ST_SCAN;
                scan_addr <= '0;
                found     <= 1'b0;
              end
            end
          end else if (out_ready) begin
            out_valid   <= 1'b1;
            out_slot    <= held_valid ? ID_W'(held_idx) : '0;
            out_outcome <= held_valid ? OUT_FIRED : OUT_NONE_DUE;
            out_last    <= 1'b1;
            state       <= ST_IDLE;
          end
        end

        ST_FLUSH: begin
          if (out_ready) begin
            out_valid   <= 1'b1;
            out_slot    <= ID_W'(held_idx);
            out_outcome <= OUT_FIRED;
            out_last    <= 1'b1;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_slot);
  assign m_tuser  = out_outcome;
  assign m_tlast  = out_last;

endmodule

/* design/deadline_timer_table_top.sv */
// ----------------------------------------------------------------------------
// Deadline timer table
// A table of one-shot timers with arm, cancel, expire-now and tick commands.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ channel; the opcode rides on s_tuser and the
// slot, delay and current time on s_tdata. Each result leaves on the m_
// channel: slot on m_tdata, outcome on m_tuser, and m_tlast set on the final
// result of a command.
// Arm, cancel and expire-now give one result each, moving from the queue
// through the back end's idle and exec states into the output register; the
// back end takes no new command until that result is issued. A tick searches
// the deadline RAM one slot per cycle, in search passes over the table; a
// tick that fires k timers takes (k + 1) passes, since the last mark of a
// fired result is known only once the next pass has found nothing further
// due. A tick that reaches the result limit stops after its last firing pass.
// A two-entry command queue lets the input keep taking transfers while the
// back end works, and the output register holds a result while the receiver
// stalls; the back end simply waits for it.
// Reset clears the pending flags at once, so every timer is idle right after
// reset; the deadline RAM needs no clearing because a deadline read during a
// search is only used for a slot whose pending flag is set.
// ----------------------------------------------------------------------------
`include "deadline_timer_table_top_macros.svh"

module deadline_timer_table_top import dtt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // s_tdata, low bit up: timer_id[4:0], delay_seconds[15:0], now_sec[31:0],
  // now_usec[19:0], zero fill.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: opcode[1:0].
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata, low bit up: slot_id[4:0], zero fill.
  output logic [M_TDATA_W-1:0] m_tdata,
  // m_tuser: outcome[1:0].
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  // Command queue between the decoding front end and the executing back end.
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  dtt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  dtt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // A "none due" report is always the single result of its tick, for slot 0.
  `DTT_ASSERT_NOW(a_none_due_alone, m_tvalid && (m_tuser == OUT_NONE_DUE), m_tlast && (m_tdata == '0))

  // Only fired results can be followed by more results of the same command.
  `DTT_ASSERT_NOW(a_single_result, m_tvalid && (m_tuser != OUT_FIRED), m_tlast)

  // An accepted transfer is waiting in the queue on the next cycle.
  `DTT_ASSERT_NEXT(a_queued, s_tvalid && s_tready, q_valid)

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadline timer table testbench
// Drives arm, cancel, expire-now and tick commands into the timer table and
// checks every result against a cycle-free model of the slot table. Directed
// corner cases come first, then four phases of random command episodes under
// different amounts of input idling and output back-pressure.
// ----------------------------------------------------------------------------
import dtt_pkg::*;

// One result the timer table owes us.
typedef struct {
  logic [ID_W-1:0] slot;
  outcome_t        outcome;
  logic            last;
} timer_reply_t;

// Model of the slot table. Each accepted command updates the slots and appends
// the replies it causes; each result from the block is matched to the oldest.
class deadline_tracker;
  logic [SEC_W-1:0]  when_sec  [NUM_TIMERS];
  logic [USEC_W-1:0] when_usec [NUM_TIMERS];
  bit                armed     [NUM_TIMERS];
  timer_reply_t      reply_q[$];
  int                fail_count;

  function new();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      when_sec[i]  = '0;
      when_usec[i] = '0;
      armed[i]     = 1'b0;
    end
    fail_count = 0;
  endfunction

  function void push_reply(int slot, outcome_t outcome, logic last);
    timer_reply_t r;
    r.slot    = slot[ID_W-1:0];
    r.outcome = outcome;
    r.last    = last;
    reply_q.push_back(r);
  endfunction

  function void disarm(int slot);
    armed[slot]     = 1'b0;
    when_sec[slot]  = '0;
    when_usec[slot] = '0;
  endfunction

  function void note_command(opcode_t op, logic [ID_W-1:0] id, logic [DELAY_W-1:0] delay,
                             logic [SEC_W-1:0] ns, logic [USEC_W-1:0] nu);
    logic [SEC_W:0] sum;
    int fired;
    int best;
    bit found;
    case (op)
      OP_TICK: begin
        // Repeated minimum search over the due slots; seconds then micros
        // compare as one concatenated value, ties go to the lower index.
        fired = 0;
        while (fired < RESULT_LIMIT) begin
          found = 1'b0;
          best  = 0;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (armed[i] && {when_sec[i], when_usec[i]} <= {ns, nu}) begin
              if (!found || {when_sec[i], when_usec[i]} < {when_sec[best], when_usec[best]})
              begin
                best  = i;
                found = 1'b1;
              end
            end
          end
          if (!found) break;
          disarm(best);
          push_reply(best, OUT_FIRED, 1'b0);
          fired++;
        end
        if (fired == 0) push_reply(0, OUT_NONE_DUE, 1'b1);
        else reply_q[reply_q.size() - 1].last = 1'b1;
      end
      OP_ARM: begin
        sum = {1'b0, ns} + {{(SEC_W + 1 - DELAY_W){1'b0}}, delay};
        when_sec[id]  = sum[SEC_W] ? '1 : sum[SEC_W-1:0];
        when_usec[id] = nu;
        armed[id]     = 1'b1;
        push_reply(int'(id), OUT_DONE, 1'b1);
      end
      OP_CANCEL: begin
        if (armed[id]) begin
          disarm(int'(id));
          push_reply(int'(id), OUT_DONE, 1'b1);
        end else begin
          push_reply(int'(id), OUT_NOT_PENDING, 1'b1);
        end
      end
      default: begin
        when_sec[id]  = ns;
        when_usec[id] = nu;
        armed[id]     = 1'b1;
        push_reply(int'(id), OUT_DONE, 1'b1);
      end
    endcase
  endfunction

  function void mismatch(string field, int want, int got);
    fail_count++;
    if (fail_count <= 30)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  function void check_result(logic [ID_W-1:0] slot, logic [1:0] outcome, logic last);
    timer_reply_t want;
    if (reply_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 30)
        $display("%0t: unexpected result, expected none, actual slot %0d outcome %0d last %0d",
                 $time, slot, outcome, last);
      return;
    end
    want = reply_q.pop_front();
    if (slot !== want.slot) mismatch("slot_id", int'(want.slot), int'(slot));
    if (outcome !== want.outcome) mismatch("outcome", int'(want.outcome), int'(outcome));
    if (last !== want.last) mismatch("last_result", int'(want.last), int'(last));
  endfunction
endclass

module tb;

  // Generous bound: a full table tick costs 32 search passes, and stalls on
  // both sides can roughly double the time it takes.
  localparam int CYCLE_LIMIT = 2_000_000;
  // Quiet time after the last owed result, a bit over two search passes.
  localparam int SETTLE_CYCLES = 2 * (NUM_TIMERS + 3);
  localparam int PHASE_ITEMS = 62;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;

  deadline_tracker tracker;
  int              sender_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              items_sent = 0;
  int              cycle_count = 0;
  logic [SEC_W-1:0] sim_sec = 32'd1000;

  deadline_timer_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs or owes results it never delivers.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver side. The ready seen here is the one from before the edge, so a
  // transfer is judged on exactly what the block saw. A new random ready is
  // then scheduled for the next cycle.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_result(m_tdata[ID_W-1:0], m_tuser, m_tlast);
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one command and holds it until the block takes the transfer. The
  // model is updated here rather than in a separate monitor, so the count of
  // owed results is never behind the sender. Every call starts right after a
  // rising edge, and tvalid is written at most once per edge.
  task automatic send_cmd(input opcode_t op, input logic [ID_W-1:0] id,
                          input logic [DELAY_W-1:0] delay, input logic [SEC_W-1:0] ns,
                          input logic [USEC_W-1:0] nu);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      // Mostly short gaps, sometimes long enough to land inside a tick search.
      if ($urandom_range(9) == 0) repeat ($urandom_range(7, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, nu, ns, delay, id};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    tracker.note_command(op, id, delay, ns, nu);
    items_sent++;
  endtask

  // Stops sending and waits for every owed result, then lets the block
  // settle so that a stray extra result would still be caught.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tracker.reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Seconds plus an offset, clamped at the top of the range.
  function automatic logic [SEC_W-1:0] later_sec(logic [SEC_W-1:0] s, int unsigned d);
    logic [SEC_W:0] sum;
    sum = {1'b0, s} + {1'b0, d};
    return sum[SEC_W] ? '1 : sum[SEC_W-1:0];
  endfunction

  // Micros are usually legal, but now and then above 999999 up to all ones.
  function automatic logic [USEC_W-1:0] pick_usec();
    if ($urandom_range(99) < 8) return USEC_W'($urandom_range(1_000_000, 1_048_575));
    return USEC_W'($urandom_range(0, 999_999));
  endfunction

  // One random episode: either a fully random command, or a short burst of
  // arm, expire-now and cancel commands around one time base followed by a
  // tick a little later, so that ticks find due timers to fire.
  task automatic run_episode();
    logic [SEC_W-1:0] base;
    int burst;
    int pick;
    logic [ID_W-1:0] id;
    logic [DELAY_W-1:0] delay;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_cmd(opcode_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 31)),
               DELAY_W'($urandom_range(0, 65535)), $urandom(),
               USEC_W'($urandom_range(0, 1_048_575)));
      return;
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      base    = sim_sec;
      sim_sec = later_sec(sim_sec, $urandom_range(0, 20));
    end else if (pick < 85) begin
      base = $urandom();
    end else begin
      base = 32'hFFFF_FFFF - $urandom_range(0, 70000);
    end
    burst = $urandom_range(1, 6);
    repeat (burst) begin
      pick = $urandom_range(99);
      id   = ID_W'($urandom_range(0, 31));
      if (pick < 45) begin
        delay = ($urandom_range(3) == 0) ? DELAY_W'($urandom_range(0, 65535))
                                         : DELAY_W'($urandom_range(0, 6));
        send_cmd(OP_ARM, id, delay, later_sec(base, $urandom_range(0, 2)), pick_usec());
      end else if (pick < 75) begin
        send_cmd(OP_EXPIRE, id, DELAY_W'($urandom_range(0, 65535)),
                 later_sec(base, $urandom_range(0, 2)), pick_usec());
      end else begin
        send_cmd(OP_CANCEL, id, DELAY_W'($urandom_range(0, 65535)), $urandom(), pick_usec());
      end
    end
    // An occasional tick at the largest seconds value fires everything still pending, but for larger micros there.
    if ($urandom_range(19) == 0)
      send_cmd(OP_TICK, ID_W'($urandom_range(0, 31)), DELAY_W'($urandom_range(0, 65535)),
               32'hFFFF_FFFF, USEC_W'($urandom_range(0, 1_048_575)));
    else
      send_cmd(OP_TICK, ID_W'($urandom_range(0, 31)), DELAY_W'($urandom_range(0, 65535)),
               later_sec(base, $urandom_range(0, 8)), pick_usec());
  endtask

  initial begin
    int target;
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with both sides always ready.
    send_cmd(OP_TICK, 5'd0, 16'd0, 32'd0, 20'd0);               // empty table: none due
    send_cmd(OP_CANCEL, 5'd0, 16'd0, 32'd0, 20'd0);             // cancel of an idle slot
    send_cmd(OP_ARM, 5'd31, 16'hFFFF, 32'hFFFF_FFF0, 20'd999_999); // seconds saturate
    send_cmd(OP_ARM, 5'd0, 16'd0, 32'd0, 20'd0);                // zero deadline
    send_cmd(OP_EXPIRE, 5'd5, 16'd0, 32'd100, 20'hF_FFFF);     // micros above range
    send_cmd(OP_ARM, 5'd7, 16'd10, 32'd100, 20'd500);
    send_cmd(OP_ARM, 5'd3, 16'd10, 32'd100, 20'd500);          // same deadline as slot 7
    send_cmd(OP_ARM, 5'd9, 16'd5, 32'd100, 20'd123);
    send_cmd(OP_ARM, 5'd9, 16'd20, 32'd100, 20'd123);          // re-arm replaces
    send_cmd(OP_CANCEL, 5'd5, 16'd0, 32'd0, 20'd0);            // pending: done
    send_cmd(OP_CANCEL, 5'd5, 16'd0, 32'd0, 20'd0);            // already cleared
    send_cmd(OP_EXPIRE, 5'd12, 16'd0, 32'd110, 20'd499);
    send_cmd(OP_TICK, 5'd0, 16'd0, 32'd110, 20'd499);          // fires slots 0 and 12
    send_cmd(OP_TICK, 5'd0, 16'd0, 32'd110, 20'd500);          // tie: slot 3 before 7
    send_cmd(OP_EXPIRE, 5'd20, 16'd0, 32'd200, 20'hF_FFFF);
    send_cmd(OP_TICK, 5'd0, 16'd0, 32'd200, 20'd999_999);      // slot 9 fires, slot 20 not: micros compare as given
    send_cmd(OP_TICK, 5'd0, 16'd0, 32'd200, 20'hF_FFFF);       // now slot 20 fires
    send_cmd(OP_TICK, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 20'hF_FFFF); // slot 31
    send_cmd(OP_TICK, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 20'hF_FFFF); // nothing left

    // The sender holds off here until the block has answered everything.
    wait_drained();

    // Random phases with different idle and stall mixes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 47;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 47;
        end
        default: begin
          sender_idle_pct = 35;
          recv_stall_pct  = 35;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      // Once, load every slot and fire the whole table with a single tick.
      if (phase == 2) begin
        for (int k = 0; k < NUM_TIMERS; k++)
          send_cmd(OP_EXPIRE, ID_W'(k), DELAY_W'($urandom_range(0, 65535)),
                   sim_sec - $urandom_range(0, 3), pick_usec());
        send_cmd(OP_TICK, 5'd0, 16'd0, later_sec(sim_sec, 5), 20'd0);
      end
      while (items_sent < target) run_episode();
      wait_drained();
    end

    if (tracker.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/dtt_pkg.sv
design/dtt_ram.sv
design/dtt_front.sv
design/dtt_back.sv
design/deadline_timer_table_top.sv
bench/tb.sv
